// ===== hw/rtl/swstat_pkg.sv =====
// ----------------------------------------------------------------------------
// swstat_pkg
// Shared types, constants and helpers of the sensor window statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package swstat_pkg;

	// window lengths in samples; zero behaves as one
	localparam int SHORT_LEN = 10;
	localparam int MID_LEN   = 60;
	localparam int LONG_LEN  = 600;

	localparam int N_SHORT = (SHORT_LEN == 0) ? 1 : SHORT_LEN;
	localparam int N_MID   = (MID_LEN == 0) ? 1 : MID_LEN;
	localparam int N_LONG  = (LONG_LEN == 0) ? 1 : LONG_LEN;

	localparam int SAMPLE_W = 12;
	localparam int VAL_W    = 11;
	localparam int NUM_WIN  = 3;

	// scaling to tenths: value = floor(sample * SCALE_NUM / 4095)
	localparam int SCALE_NUM = 1000;
	localparam int RAW_W     = 22;
	localparam int DIV_SH    = 12;
	localparam int TEMP_OFS  = 500;
	localparam int TEMP_MIN  = 500;
	localparam int TEMP_MAX  = 1500;
	localparam int HUM_MAX   = 999;
	localparam int VAL_MAX   = 1500;

	localparam int SUM_S_W = $clog2(N_SHORT * VAL_MAX + 1);
	localparam int SUM_M_W = $clog2(N_MID * VAL_MAX + 1);
	localparam int SUM_L_W = $clog2(N_LONG * VAL_MAX + 1);
	localparam int CNT_S_W = $clog2(N_SHORT + 1);
	localparam int CNT_M_W = $clog2(N_MID + 1);
	localparam int CNT_L_W = $clog2(N_LONG + 1);

	localparam int SUM_MAX_W = (SUM_S_W > SUM_M_W) ?
		((SUM_S_W > SUM_L_W) ? SUM_S_W : SUM_L_W) :
		((SUM_M_W > SUM_L_W) ? SUM_M_W : SUM_L_W);

	// average by reciprocal: floor(sum * REC / 2^AVG_SH), exact for all sums
	localparam int SH_S = SUM_S_W + $clog2(N_SHORT);
	localparam int SH_M = SUM_M_W + $clog2(N_MID);
	localparam int SH_L = SUM_L_W + $clog2(N_LONG);
	localparam int AVG_SH = (SH_S > SH_M) ? ((SH_S > SH_L) ? SH_S : SH_L) :
		((SH_M > SH_L) ? SH_M : SH_L);
	localparam int REC_W  = AVG_SH + 1;
	localparam int PROD_W = SUM_MAX_W + REC_W;

	localparam logic [REC_W-1:0] REC_S =
		REC_W'(((longint'(1) << AVG_SH) + longint'(N_SHORT) - 1) / longint'(N_SHORT));
	localparam logic [REC_W-1:0] REC_M =
		REC_W'(((longint'(1) << AVG_SH) + longint'(N_MID) - 1) / longint'(N_MID));
	localparam logic [REC_W-1:0] REC_L =
		REC_W'(((longint'(1) << AVG_SH) + longint'(N_LONG) - 1) / longint'(N_LONG));

	localparam logic [1:0] WIN_SHORT = 2'd0;
	localparam logic [1:0] WIN_MID   = 2'd1;
	localparam logic [1:0] WIN_LONG  = 2'd2;

	typedef logic [VAL_W-1:0] val_t;

	typedef enum logic [1:0] {
		KIND_INSTANT = 2'd0,
		KIND_SHORT   = 2'd1,
		KIND_MID     = 2'd2,
		KIND_LONG    = 2'd3
	} kind_t;

	typedef struct packed {
		logic                channel;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic  channel_out;
		kind_t kind;
		val_t  average;
		val_t  maximum;
		val_t  minimum;
		logic  last;
	} out_item_t;

	// scaled sample leaving the first stage
	typedef struct packed {
		logic valid;
		logic channel;
		val_t value;
	} scaled_t;

	// one memory word: all window state of one channel
	typedef struct packed {
		logic [SUM_L_W-1:0]  long_sum;
		logic [SUM_M_W-1:0]  mid_sum;
		logic [SUM_S_W-1:0]  short_sum;
		logic [CNT_L_W-1:0]  long_cnt;
		logic [CNT_M_W-1:0]  mid_cnt;
		logic [CNT_S_W-1:0]  short_cnt;
		val_t [NUM_WIN-1:0]  win_max;
		val_t [NUM_WIN-1:0]  win_min;
	} chan_state_t;

	// work handed to the result sequencer
	typedef struct packed {
		logic                               channel;
		val_t                               value;
		logic [NUM_WIN-1:0]                 done;
		logic [NUM_WIN-1:0][SUM_MAX_W-1:0]  sum;
		val_t [NUM_WIN-1:0]                 win_max;
		val_t [NUM_WIN-1:0]                 win_min;
	} job_t;

	function automatic chan_state_t empty_state();
		chan_state_t st;
		st         = '0;
		st.win_min = '1;
		return st;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/swstat_scale.sv =====
// ----------------------------------------------------------------------------
// swstat_scale
// Input stage: registers the item and scales the sample to tenths.
// ----------------------------------------------------------------------------
`default_nettype none

module swstat_scale (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  swstat_pkg::in_item_t   in_data,
	output swstat_pkg::scaled_t    s1,
	input  wire                    s1_go
);

	logic                            vld_s1;
	logic                            ch_s1;
	logic [swstat_pkg::SAMPLE_W-1:0] sample_s1;
	logic [swstat_pkg::RAW_W-1:0]    raw;
	logic [swstat_pkg::RAW_W:0]      quo_t;
	swstat_pkg::val_t                q;
	swstat_pkg::val_t                v;

	assign in_ready = !vld_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1     <= in_data.channel;
			sample_s1 <= in_data.sample;
		end
	end

	always_comb begin
		raw = swstat_pkg::RAW_W'(sample_s1) * swstat_pkg::RAW_W'(swstat_pkg::SCALE_NUM);
		// floor(x / 4095) = (x + (x >> 12) + 1) >> 12 over the whole raw range
		quo_t = {1'b0, raw} + {1'b0, raw >> swstat_pkg::DIV_SH} +
			{{swstat_pkg::RAW_W{1'b0}}, 1'b1};
		q     = quo_t[swstat_pkg::DIV_SH +: swstat_pkg::VAL_W];
		if (!ch_s1) begin
			v = q + swstat_pkg::VAL_W'(swstat_pkg::TEMP_OFS);
			if (v > swstat_pkg::VAL_W'(swstat_pkg::TEMP_MAX)) begin
				v = swstat_pkg::VAL_W'(swstat_pkg::TEMP_MAX);
			end
			if (v < swstat_pkg::VAL_W'(swstat_pkg::TEMP_MIN)) begin
				v = swstat_pkg::VAL_W'(swstat_pkg::TEMP_MIN);
			end
		end else begin
			v = q;
			if (v > swstat_pkg::VAL_W'(swstat_pkg::HUM_MAX)) begin
				v = swstat_pkg::VAL_W'(swstat_pkg::HUM_MAX);
			end
		end
	end

	assign s1.valid   = vld_s1;
	assign s1.channel = ch_s1;
	assign s1.value   = v;

endmodule

`default_nettype wire

// ===== hw/rtl/swstat_state.sv =====
// ----------------------------------------------------------------------------
// swstat_state
// Per-channel window state memory with read-modify-write and forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module swstat_state (
	input  wire                      clk,
	input  wire                      arst_n,
	input  swstat_pkg::scaled_t      s1,
	output logic                     s1_go,
	output logic                     job_valid,
	output swstat_pkg::job_t         job,
	input  wire                      job_take
);

	swstat_pkg::chan_state_t mem_q [2];
	logic [1:0]              ent_vld_q;

	logic                    vld_s2;
	logic                    ch_s2;
	swstat_pkg::val_t        v_s2;
	logic                    rd_vld_s2;
	logic                    bypass_s2;
	swstat_pkg::chan_state_t rd_data_s2;
	swstat_pkg::chan_state_t wb_q;

	logic                    s2_go;
	swstat_pkg::chan_state_t cur;
	swstat_pkg::chan_state_t nxt;
	swstat_pkg::job_t        jb;

	logic [swstat_pkg::SUM_S_W-1:0] s_sum;
	logic [swstat_pkg::SUM_M_W-1:0] m_sum;
	logic [swstat_pkg::SUM_L_W-1:0] l_sum;
	logic [swstat_pkg::CNT_S_W-1:0] s_cnt;
	logic [swstat_pkg::CNT_M_W-1:0] m_cnt;
	logic [swstat_pkg::CNT_L_W-1:0] l_cnt;
	swstat_pkg::val_t [swstat_pkg::NUM_WIN-1:0] mx;
	swstat_pkg::val_t [swstat_pkg::NUM_WIN-1:0] mn;

	assign s2_go     = vld_s2 && job_take;
	assign s1_go     = s1.valid && (!vld_s2 || s2_go);
	assign job_valid = vld_s2;
	assign job       = jb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			ent_vld_q <= '0;
			bypass_s2 <= 1'b0;
		end else begin
			if (s1_go) begin
				vld_s2 <= 1'b1;
				// same entry written at this edge: the read sees stale data
				bypass_s2 <= s2_go && (ch_s2 == s1.channel);
			end else if (s2_go) begin
				vld_s2 <= 1'b0;
			end
			if (s2_go) begin
				ent_vld_q[ch_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			rd_data_s2 <= mem_q[s1.channel];
			rd_vld_s2  <= ent_vld_q[s1.channel];
			ch_s2      <= s1.channel;
			v_s2       <= s1.value;
		end
		if (s2_go) begin
			mem_q[ch_s2] <= nxt;
			wb_q         <= nxt;
		end
	end

	always_comb begin
		if (bypass_s2) begin
			cur = wb_q;
		end else if (rd_vld_s2) begin
			cur = rd_data_s2;
		end else begin
			cur = swstat_pkg::empty_state();
		end

		for (int w = 0; w < swstat_pkg::NUM_WIN; w++) begin
			mx[w] = (v_s2 > cur.win_max[w]) ? v_s2 : cur.win_max[w];
			mn[w] = (v_s2 < cur.win_min[w]) ? v_s2 : cur.win_min[w];
		end

		s_sum = cur.short_sum + swstat_pkg::SUM_S_W'(v_s2);
		m_sum = cur.mid_sum + swstat_pkg::SUM_M_W'(v_s2);
		l_sum = cur.long_sum + swstat_pkg::SUM_L_W'(v_s2);
		s_cnt = cur.short_cnt + swstat_pkg::CNT_S_W'(1);
		m_cnt = cur.mid_cnt + swstat_pkg::CNT_M_W'(1);
		l_cnt = cur.long_cnt + swstat_pkg::CNT_L_W'(1);

		jb         = '0;
		jb.channel = ch_s2;
		jb.value   = v_s2;
		jb.done[swstat_pkg::WIN_SHORT] = (s_cnt == swstat_pkg::CNT_S_W'(swstat_pkg::N_SHORT));
		jb.done[swstat_pkg::WIN_MID]   = (m_cnt == swstat_pkg::CNT_M_W'(swstat_pkg::N_MID));
		jb.done[swstat_pkg::WIN_LONG]  = (l_cnt == swstat_pkg::CNT_L_W'(swstat_pkg::N_LONG));
		jb.sum[swstat_pkg::WIN_SHORT]  = swstat_pkg::SUM_MAX_W'(s_sum);
		jb.sum[swstat_pkg::WIN_MID]    = swstat_pkg::SUM_MAX_W'(m_sum);
		jb.sum[swstat_pkg::WIN_LONG]   = swstat_pkg::SUM_MAX_W'(l_sum);
		jb.win_max = mx;
		jb.win_min = mn;

		// a filled window restarts empty
		nxt           = cur;
		nxt.short_sum = jb.done[swstat_pkg::WIN_SHORT] ? '0 : s_sum;
		nxt.short_cnt = jb.done[swstat_pkg::WIN_SHORT] ? '0 : s_cnt;
		nxt.mid_sum   = jb.done[swstat_pkg::WIN_MID] ? '0 : m_sum;
		nxt.mid_cnt   = jb.done[swstat_pkg::WIN_MID] ? '0 : m_cnt;
		nxt.long_sum  = jb.done[swstat_pkg::WIN_LONG] ? '0 : l_sum;
		nxt.long_cnt  = jb.done[swstat_pkg::WIN_LONG] ? '0 : l_cnt;
		for (int w = 0; w < swstat_pkg::NUM_WIN; w++) begin
			nxt.win_max[w] = jb.done[w] ? '0 : mx[w];
			nxt.win_min[w] = jb.done[w] ? '1 : mn[w];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/swstat_emit.sv =====
// ----------------------------------------------------------------------------
// swstat_emit
// Result sequencer: instant result, then each filled window's average,
// maximum and minimum, through one shared reciprocal multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module swstat_emit (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    job_valid,
	input  swstat_pkg::job_t       job,
	output logic                   job_take,
	output logic                   out_valid,
	input  wire                    out_ready,
	output swstat_pkg::out_item_t  out_data
);

	logic [3:0]             mask_q;
	swstat_pkg::job_t       job_q;
	logic                   out_vld_q;
	swstat_pkg::out_item_t  out_q;

	logic                   out_can;
	logic                   emit;
	logic [3:0]             pick;
	logic [3:0]             rest;
	swstat_pkg::kind_t      kind;
	logic [1:0]             w_sel;
	logic [swstat_pkg::SUM_MAX_W-1:0] sum_sel;
	logic [swstat_pkg::REC_W-1:0]     rec_sel;
	logic [swstat_pkg::PROD_W-1:0]    prod;
	swstat_pkg::out_item_t  item;

	assign out_can   = !out_vld_q || out_ready;
	assign emit      = (mask_q != '0) && out_can;
	assign rest      = mask_q & ~pick;
	assign job_take  = (mask_q == '0) || (emit && (rest == '0));
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_comb begin
		priority if (mask_q[0]) begin
			pick = 4'b0001;
			kind = swstat_pkg::KIND_INSTANT;
		end else if (mask_q[1]) begin
			pick = 4'b0010;
			kind = swstat_pkg::KIND_SHORT;
		end else if (mask_q[2]) begin
			pick = 4'b0100;
			kind = swstat_pkg::KIND_MID;
		end else begin
			pick = 4'b1000;
			kind = swstat_pkg::KIND_LONG;
		end

		unique case (kind)
			swstat_pkg::KIND_SHORT: begin
				w_sel   = swstat_pkg::WIN_SHORT;
				rec_sel = swstat_pkg::REC_S;
			end
			swstat_pkg::KIND_MID: begin
				w_sel   = swstat_pkg::WIN_MID;
				rec_sel = swstat_pkg::REC_M;
			end
			swstat_pkg::KIND_LONG: begin
				w_sel   = swstat_pkg::WIN_LONG;
				rec_sel = swstat_pkg::REC_L;
			end
			default: begin
				w_sel   = swstat_pkg::WIN_SHORT;
				rec_sel = '0;
			end
		endcase

		sum_sel = job_q.sum[w_sel];
		prod    = swstat_pkg::PROD_W'(sum_sel) * swstat_pkg::PROD_W'(rec_sel);

		item.channel_out = job_q.channel;
		item.kind        = kind;
		item.last        = (rest == '0);
		if (kind == swstat_pkg::KIND_INSTANT) begin
			item.average = job_q.value;
			item.maximum = job_q.value;
			item.minimum = job_q.value;
		end else begin
			item.average = prod[swstat_pkg::AVG_SH +: swstat_pkg::VAL_W];
			item.maximum = job_q.win_max[w_sel];
			item.minimum = job_q.win_min[w_sel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (job_take && job_valid) begin
				mask_q <= {job.done, 1'b1};
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take && job_valid) begin
			job_q <= job;
		end
		if (emit) begin
			out_q <= item;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_window_statistics.sv =====
// ----------------------------------------------------------------------------
// sensor_window_statistics
// Scales converter samples to tenths and reports instant values and
// short, medium and long window average, maximum and minimum per channel.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   in        input       in_valid / in_ready     in_data  (channel, sample)
//   out       output      out_valid / out_ready   out_data (channel_out, kind,
//                                                  average, maximum, minimum, last)
//
// an item gives 1 to 4 results; the result sequencer and its shared average
// multiplier send one result per cycle, while the output is not stalled, into
// the output register; the first result of an item passes the input stage, the
// state read-modify-write, the sequencer, then the output register
// window state sits in a two-entry memory, one word per channel; a back-to-back
// item on the same channel takes the just-written word through a forward path
// reset clears all windows at once through per-entry valid bits
// a stalled output holds the pipeline; items keep entering while stages are free
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_window_statistics (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  swstat_pkg::in_item_t   in_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output swstat_pkg::out_item_t  out_data
);

	swstat_pkg::scaled_t s1;
	logic                s1_go;
	logic                job_valid;
	swstat_pkg::job_t    job;
	logic                job_take;

	swstat_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.s1       (s1),
		.s1_go    (s1_go)
	);

	swstat_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.s1_go     (s1_go),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	swstat_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
